FILE: sv/mbet_pkg.sv
package mbet_pkg;

	localparam int C_W            = 32;
	localparam int CNT_W          = 12;
	localparam int FRAC_BITS_DEF  = 28;
	localparam int MUL_DW         = 32;

	localparam logic [CNT_W-1:0] MAX_ITER_RST = CNT_W'(100);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL_P,
		ST_ISSUE_X,
		ST_MUL_X,
		ST_MUL_Y,
		ST_FINISH
	} mbet_state_t;

endpackage

FILE: sv/mbet_pt_if.sv
interface mbet_pt_if import mbet_pkg::*; ();

	logic                    valid;
	logic                    ready;
	logic signed [C_W-1:0]   c_real;
	logic signed [C_W-1:0]   c_imag;

	modport source (output valid, output c_real, output c_imag, input ready);
	modport sink   (input valid, input c_real, input c_imag, output ready);

endinterface

FILE: sv/mbet_cnt_if.sv
interface mbet_cnt_if import mbet_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [CNT_W-1:0]  iteration_count;

	modport source (output valid, output iteration_count, input ready);
	modport sink   (input valid, input iteration_count, output ready);

endinterface

FILE: sv/mbet_mul.sv
module mbet_mul import mbet_pkg::*; #(
	parameter int FRACTION_BITS = FRAC_BITS_DEF,
	parameter int OPW           = FRAC_BITS_DEF + 3,
	parameter int RESW          = FRAC_BITS_DEF + 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [OPW-1:0]  a,
	input  logic [OPW-1:0]  b,
	output logic            done,
	output logic [RESW-1:0] res
);

	localparam int NCH = (OPW + MUL_DW - 1) / MUL_DW;
	localparam int BW  = NCH * MUL_DW;
	localparam int AW  = OPW + BW;
	localparam int CW  = $clog2(NCH + 1);
	localparam logic [AW-1:0]   CAP_A = AW'(1) << (FRACTION_BITS + 3);
	localparam logic [RESW-1:0] CAP   = RESW'(1) << (FRACTION_BITS + 3);

	logic [OPW-1:0]        a_q;
	logic [BW-1:0]         b_q;
	logic [AW-1:0]         acc_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [OPW+MUL_DW-1:0] pp;
	logic [AW-1:0]         sh;

	// one digit of b per cycle while busy, top digit first
	assign pp = a_q * b_q[BW-1 -: MUL_DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NCH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= BW'(b);
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q << MUL_DW) + AW'(pp);
			b_q   <= b_q << MUL_DW;
		end
	end

	// drop fraction bits, saturate at eight
	always_comb begin
		sh = acc_q >> FRACTION_BITS;
		if (sh > CAP_A) begin
			res = CAP;
		end else begin
			res = sh[RESW-1:0];
		end
	end

	assign done = done_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("multiply started while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("multiply done held for more than one cycle");
`endif

endmodule

FILE: sv/mandelbrot_escape_time.sv
// channel  | modport | payload                      | handshake
// point    | sink    | c_real, c_imag (Q4.28)       | valid / ready
// result   | source  | iteration_count              | valid / ready
// cfg      | -       | cfg_wr_data (max_iterations) | cfg_wr_en, no wait
//
// NCH = ceil((FRACTION_BITS + 3) / 32) passes of the shared multiplier, 1 by default
// three multiplies per iteration (xy, x^2, y^2) all go through the one multiplier
// point.ready is high only while idle; a finished count waits in the output register
// reset sets max_iterations to 100 and empties the output register
module mandelbrot_escape_time import mbet_pkg::*; #(
	parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	mbet_pt_if.sink           point,
	mbet_cnt_if.source        result,
	input  logic              cfg_wr_en,
	input  logic [CNT_W-1:0]  cfg_wr_data
);

	localparam int MW = FRACTION_BITS + 3;
	localparam int SW = FRACTION_BITS + 4;
	localparam int XW = ((FRACTION_BITS + 5 > C_W) ? FRACTION_BITS + 5 : C_W) + 2;
	localparam logic [MW-1:0] OPND_LIM = MW'(1) << (FRACTION_BITS + 2);
	localparam logic [SW:0]   ESC_LIM  = (SW + 1)'(1) << (FRACTION_BITS + 2);

	mbet_state_t state_q, state_d;

	logic signed [C_W-1:0]  cr_q, ci_q;
	logic signed [XW-1:0]   x_q, y_q;
	logic [SW-1:0]          x2_q, y2_q;
	logic [CNT_W-1:0]       k_q;
	logic [CNT_W-1:0]       max_q;
	logic                   out_valid_q;
	logic [CNT_W-1:0]       out_cnt_q;

	logic                   ld_item, ld_xy, ld_x2, ld_y2, ld_out;
	logic                   mul_start, mul_done;
	logic [MW-1:0]          mul_a, mul_b;
	logic [SW-1:0]          mul_res;

	logic [XW-1:0]          abs_x, abs_y;
	logic [MW-1:0]          mag_x, mag_y;
	logic [SW:0]            sq_sum;
	logic                   stop;
	logic [XW-1:0]          twop;
	logic signed [XW-1:0]   x_new, y_new;

	// clamped magnitudes feed the multiplier
	always_comb begin
		abs_x = x_q[XW-1] ? XW'(-x_q) : XW'(x_q);
		abs_y = y_q[XW-1] ? XW'(-y_q) : XW'(y_q);
		mag_x = (abs_x > XW'(OPND_LIM)) ? OPND_LIM : abs_x[MW-1:0];
		mag_y = (abs_y > XW'(OPND_LIM)) ? OPND_LIM : abs_y[MW-1:0];
	end

	assign sq_sum = {1'b0, x2_q} + {1'b0, y2_q};
	assign stop   = (k_q >= max_q) || (sq_sum > ESC_LIM);

	// 2xy truncated toward zero, then the new point
	always_comb begin
		twop  = XW'({mul_res, 1'b0});
		y_new = ((x_q[XW-1] ^ y_q[XW-1]) ? -$signed(twop) : $signed(twop))
			+ XW'(ci_q);
		x_new = $signed(XW'(x2_q)) - $signed(XW'(y2_q)) + XW'(cr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ld_item   = 1'b0;
		ld_xy     = 1'b0;
		ld_x2     = 1'b0;
		ld_y2     = 1'b0;
		ld_out    = 1'b0;
		mul_start = 1'b0;
		mul_a     = mag_x;
		mul_b     = mag_y;
		case (state_q)
			ST_IDLE: begin
				if (point.valid) begin
					ld_item = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stop) begin
					state_d = ST_FINISH;
				end else begin
					mul_start = 1'b1;
					state_d   = ST_MUL_P;
				end
			end
			ST_MUL_P: begin
				if (mul_done) begin
					ld_xy   = 1'b1;
					state_d = ST_ISSUE_X;
				end
			end
			ST_ISSUE_X: begin
				mul_start = 1'b1;
				mul_b     = mag_x;
				state_d   = ST_MUL_X;
			end
			ST_MUL_X: begin
				mul_a = mag_y;
				if (mul_done) begin
					ld_x2     = 1'b1;
					mul_start = 1'b1;
					state_d   = ST_MUL_Y;
				end
			end
			ST_MUL_Y: begin
				if (mul_done) begin
					ld_y2   = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || result.ready) begin
					ld_out  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	mbet_mul #(
		.FRACTION_BITS (FRACTION_BITS),
		.OPW           (MW),
		.RESW          (SW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.res    (mul_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (ld_item) begin
			k_q <= '0;
		end else if (ld_y2) begin
			k_q <= k_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ld_item) begin
			cr_q <= point.c_real;
			ci_q <= point.c_imag;
			x_q  <= '0;
			y_q  <= '0;
			x2_q <= '0;
			y2_q <= '0;
		end else begin
			if (ld_xy) begin
				x_q <= x_new;
				y_q <= y_new;
			end
			if (ld_x2) begin
				x2_q <= mul_res;
			end
			if (ld_y2) begin
				y2_q <= mul_res;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_ITER_RST;
		end else if (cfg_wr_en) begin
			max_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_cnt_q <= k_q;
		end
	end

	assign point.ready            = (state_q == ST_IDLE);
	assign result.valid           = out_valid_q;
	assign result.iteration_count = out_cnt_q;

`ifndef SYNTHESIS
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_MUL_P || state_q == ST_MUL_X || state_q == ST_MUL_Y))
		else $error("multiply result arrived outside a wait state");
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (k_q <= max_q))
		else $error("iteration count passed the maximum");
	a_item_start: assert property (@(posedge clk) disable iff (!arst_n)
		(point.valid && point.ready) |=> (state_q == ST_CHECK && k_q == '0))
		else $error("accepted item did not start from zero");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.iteration_count <= max_q))
		else $error("returned count above the maximum");
`endif

endmodule
